@@ rtl/qps_pkg.sv @@
package qps_pkg;

    localparam int CountWidth = 32;
    localparam int PaddrWidth = 3;
    localparam int DataWidth  = 32;

    localparam logic [15:0] CountsPerRevReset = 16'd2000;
    localparam logic [7:0]  DeadTimeReset     = 8'd2;
    localparam logic [8:0]  DegPerRev         = 9'd360;

    localparam logic RegCountsPerRev = 1'b0;
    localparam logic RegDeadTime     = 1'b1;

    localparam logic [1:0] KindNone       = 2'd0;
    localparam logic [1:0] KindSaveCenter = 2'd1;
    localparam logic [1:0] KindMoveCenter = 2'd2;
    localparam logic [1:0] KindMoveZero   = 2'd3;

    localparam logic [1:0] DirNone = 2'd0;
    localparam logic [1:0] DirFwd  = 2'd1;
    localparam logic [1:0] DirBack = 2'd2;

    typedef struct packed {
        logic [15:0] counts_per_rev;
        logic [7:0]  dead_time_ticks;
    } t_cfg;

    function automatic logic signed [31:0] f_count_out(input logic [CountWidth-1:0] v);
        logic [63:0] ext;
        ext = 64'(signed'(v));
        return ext[31:0];
    endfunction

endpackage

@@ rtl/quadrature_position_servo_top.sv @@
// Quadrature position servo.
// Input channel (i_in_valid / o_in_ready) carries one transaction per tick:
// sampled encoder levels i_enc_a, i_enc_b and a command i_kind.
// Output channel (o_out_valid / i_out_ready) returns one transaction per input:
// drive pins, the wrapping position count, the saved center and busy_res.
// Throughput is one transaction per cycle while the receiver takes results; a result
// passes through the input register, then the decode/servo step that
// writes the result register. The single decode/servo step sets the rate.
// Configuration goes through the APB port: counts_per_rev at 0x0,
// dead_time_ticks at 0x4; write only while no transaction is in flight.
// Reset clears position, center, move state and both pipeline stages and
// loads counts_per_rev = 2000, dead_time_ticks = 2.
// When the receiver stalls, the result register holds, the input register
// fills, and o_in_ready drops; no transaction is lost and no tick is skipped.
module quadrature_position_servo_top
    import qps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_enc_a,
    input  logic                  i_enc_b,
    input  logic [1:0]            i_kind,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_drive_forward,
    output logic                  o_drive_backward,
    output logic signed [31:0]    o_position,
    output logic signed [31:0]    o_center,
    output logic                  o_busy_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PaddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0]  pwdata,
    output logic [DataWidth-1:0]  prdata,
    output logic                  pready
);

    t_cfg       w_cfg;
    logic       r_in_valid;
    logic       r_enc_a;
    logic       r_enc_b;
    logic [1:0] r_kind;
    logic       w_stage_ready;
    logic       w_adv;

    assign w_adv      = r_in_valid && w_stage_ready;
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_enc_a <= i_enc_a;
            r_enc_b <= i_enc_b;
            r_kind  <= i_kind;
        end
    end

    qps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    qps_servo u_servo (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_valid          (r_in_valid),
        .i_enc_a          (r_enc_a),
        .i_enc_b          (r_enc_b),
        .i_kind           (r_kind),
        .o_ready          (w_stage_ready),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_drive_forward  (o_drive_forward),
        .o_drive_backward (o_drive_backward),
        .o_position       (o_position),
        .o_center         (o_center),
        .o_busy_res       (o_busy_res)
    );

endmodule

@@ rtl/qps_regs.sv @@
module qps_regs
    import qps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PaddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0]  pwdata,
    output logic [DataWidth-1:0]  prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (paddr[2])
                RegCountsPerRev: n_cfg.counts_per_rev = pwdata[15:0];
                RegDeadTime:     n_cfg.dead_time_ticks = pwdata[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.counts_per_rev  <= CountsPerRevReset;
            r_cfg.dead_time_ticks <= DeadTimeReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[2])
            RegCountsPerRev: prdata = {16'd0, r_cfg.counts_per_rev};
            RegDeadTime:     prdata = {24'd0, r_cfg.dead_time_ticks};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/qps_servo.sv @@
module qps_servo
    import qps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  logic               i_enc_a,
    input  logic               i_enc_b,
    input  logic [1:0]         i_kind,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_drive_forward,
    output logic               o_drive_backward,
    output logic signed [31:0] o_position,
    output logic signed [31:0] o_center,
    output logic               o_busy_res
);

    logic [CountWidth-1:0] r_pos, n_pos;
    logic [CountWidth-1:0] r_center, n_center;
    logic [CountWidth-1:0] r_target, n_target;
    logic                  r_prev_a, r_prev_b;
    logic                  r_moving, n_moving;
    logic [1:0]            r_dir, n_dir;
    logic [7:0]            r_pause, n_pause;

    logic                  r_out_valid;
    logic                  r_fwd, n_fwd;
    logic                  r_back, n_back;
    logic signed [31:0]    r_position;
    logic signed [31:0]    r_center_out;
    logic                  r_busy;

    logic                  w_adv;
    logic signed [2:0]     w_step;
    logic signed [CountWidth:0] w_diff;
    logic [CountWidth:0]   w_mag;
    logic [16:0]           w_prod;
    logic                  w_in_band;
    logic [1:0]            w_want;

    assign o_ready = !r_out_valid || i_ready;
    assign w_adv   = i_valid && o_ready;

    always_comb begin
        w_step = 3'sd0;
        if (i_enc_a != r_prev_a) begin
            w_step = (i_enc_a == i_enc_b) ? w_step + 3'sd1 : w_step - 3'sd1;
        end
        if (i_enc_b != r_prev_b) begin
            w_step = (i_enc_a != i_enc_b) ? w_step + 3'sd1 : w_step - 3'sd1;
        end
        n_pos = r_pos + CountWidth'(w_step);

        n_center = r_center;
        n_target = r_target;
        n_moving = r_moving;
        n_dir    = r_dir;
        n_pause  = r_pause;
        if (!r_moving) begin
            case (i_kind)
                KindSaveCenter: n_center = n_pos;
                KindMoveCenter: begin
                    n_target = r_center;
                    n_moving = 1'b1;
                    n_dir    = DirNone;
                    n_pause  = 8'd0;
                end
                KindMoveZero: begin
                    n_target = '0;
                    n_moving = 1'b1;
                    n_dir    = DirNone;
                    n_pause  = 8'd0;
                end
                default: n_moving = r_moving;
            endcase
        end

        w_diff    = $signed({n_target[CountWidth-1], n_target})
                  - $signed({n_pos[CountWidth-1], n_pos});
        w_mag     = w_diff[CountWidth] ? (CountWidth+1)'(-w_diff) : w_diff;
        w_prod    = 17'(w_mag[7:0]) * 17'(DegPerRev);
        w_in_band = (w_mag[CountWidth:8] == '0) && (w_prod < {1'b0, i_cfg.counts_per_rev});
        w_want    = (!w_diff[CountWidth] && (w_diff != '0)) ? DirFwd : DirBack;

        n_fwd  = 1'b0;
        n_back = 1'b0;
        if (n_moving) begin
            if (w_in_band) begin
                n_moving = 1'b0;
                n_dir    = DirNone;
                n_pause  = 8'd0;
            end else begin
                if (n_dir != w_want) begin
                    n_dir   = w_want;
                    n_pause = i_cfg.dead_time_ticks;
                end
                if (n_pause != 8'd0) begin
                    n_pause = n_pause - 8'd1;
                end else if (n_dir == DirFwd) begin
                    n_fwd = 1'b1;
                end else begin
                    n_back = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_center    <= '0;
            r_target    <= '0;
            r_prev_a    <= 1'b0;
            r_prev_b    <= 1'b0;
            r_moving    <= 1'b0;
            r_dir       <= DirNone;
            r_pause     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_pos    <= n_pos;
                r_center <= n_center;
                r_target <= n_target;
                r_prev_a <= i_enc_a;
                r_prev_b <= i_enc_b;
                r_moving <= n_moving;
                r_dir    <= n_dir;
                r_pause  <= n_pause;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fwd        <= n_fwd;
            r_back       <= n_back;
            r_position   <= f_count_out(n_pos);
            r_center_out <= f_count_out(n_center);
            r_busy       <= n_moving;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_drive_forward  = r_fwd;
    assign o_drive_backward = r_back;
    assign o_position       = r_position;
    assign o_center         = r_center_out;
    assign o_busy_res       = r_busy;

endmodule

@@ rtl/quadrature_position_servo_chk.sv @@
module quadrature_position_servo_chk
    import qps_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_drive_forward,
    input logic               o_drive_backward,
    input logic signed [31:0] o_position,
    input logic               o_busy_res
);

    a_pins_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_drive_forward && o_drive_backward))
        else $error("both drive pins high");

    a_drive_needs_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_drive_forward || o_drive_backward) |-> o_busy_res)
        else $error("drive without a move in progress");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_position))
        else $error("stalled transaction changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind quadrature_position_servo_top quadrature_position_servo_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_drive_forward  (o_drive_forward),
    .o_drive_backward (o_drive_backward),
    .o_position       (o_position),
    .o_busy_res       (o_busy_res)
);
